>>> src/lrcas_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lrcas_pkg
// Shared types and constants of the letter range count/assign/sort unit.
// ---------------------------------------------------------------------------
package lrcas_pkg;

    localparam int MAX_LENGTH = 1024;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);
    localparam int POS_W      = 11;
    localparam int ALPHABET   = 26;
    localparam int LETTER_W   = 5;
    localparam int REQ_W      = 2;

    localparam logic [LETTER_W-1:0] EMPTY_CODE = '1;

    localparam logic [REQ_W-1:0] REQ_COUNT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ASSIGN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SORT   = 2'd2;

    typedef enum logic [1:0] {
        K_COUNT,
        K_ASSIGN,
        K_SORT,
        K_ZERO
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [POS_W-1:0]    start;
        logic [POS_W-1:0]    stop;
        logic [LETTER_W-1:0] letter;
    } t_cmd;

endpackage
`default_nettype wire

>>> src/letter_range_count_assign_sort_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// letter_range_count_assign_sort_unit
// Letter string store with range count, range assign and range sort.
// ---------------------------------------------------------------------------
// The string lives in a letter memory with one write and one read port, one
// position per word. Every request walks its range one position per cycle;
// a sort also spends steps on letters with no tally left. A sort scans once
// to tally letters, then makes one write pass. After reset a clearing pass
// over all 1024 positions empties the memory before the first request is
// taken. Requests queue two deep ahead of the executor; a count result waits
// in an output register until taken.
module letter_range_count_assign_sort_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [10:0] i_cfg_wdata,      // active_length
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,     // req_type[1:0] range_start[12:2]
                                          // range_end[23:13] letter[28:24]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata      // letter_count[10:0]
);
    logic q_full, push, pop, q_valid;
    lrcas_pkg::t_cmd in_cmd, q_cmd;
    logic [lrcas_pkg::POS_W-1:0] count;

    lrcas_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_req_type   (s_axis_tdata[1:0]),
        .i_range_start(s_axis_tdata[12:2]),
        .i_range_end  (s_axis_tdata[23:13]),
        .i_letter     (s_axis_tdata[28:24]),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (in_cmd)
    );

    lrcas_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (in_cmd),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    lrcas_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_cmd  (q_cmd),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_count  (count)
    );

    assign m_axis_tdata = {5'd0, count};

endmodule
`default_nettype wire

>>> src/lrcas_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lrcas_front
// Accepts request beats, checks range and letter, issues commands.
// ---------------------------------------------------------------------------
module lrcas_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [lrcas_pkg::POS_W-1:0]    i_cfg_wdata,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire  [lrcas_pkg::REQ_W-1:0]    i_req_type,
    input  wire  [lrcas_pkg::POS_W-1:0]    i_range_start,
    input  wire  [lrcas_pkg::POS_W-1:0]    i_range_end,
    input  wire  [lrcas_pkg::LETTER_W-1:0] i_letter,
    input  wire                            i_q_full,
    output logic                           o_push,
    output lrcas_pkg::t_cmd                o_cmd
);
    logic [lrcas_pkg::POS_W-1:0] r_active_length;
    logic [lrcas_pkg::POS_W-1:0] limit;
    logic good, letter_ok, drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_length <= lrcas_pkg::POS_W'(lrcas_pkg::MAX_LENGTH);
        end else if (i_cfg_we) begin
            r_active_length <= i_cfg_wdata;
        end
    end

    always_comb begin
        limit = (r_active_length > lrcas_pkg::POS_W'(lrcas_pkg::MAX_LENGTH)) ?
                lrcas_pkg::POS_W'(lrcas_pkg::MAX_LENGTH) : r_active_length;
        good = (i_range_start != '0) && (i_range_start <= i_range_end) &&
               (i_range_end <= limit);
        letter_ok = (i_letter < lrcas_pkg::LETTER_W'(lrcas_pkg::ALPHABET));
        drop = 1'b0;
        o_cmd.start  = i_range_start;
        o_cmd.stop   = i_range_end;
        o_cmd.letter = i_letter;
        o_cmd.kind   = lrcas_pkg::K_ZERO;
        unique case (i_req_type)
            lrcas_pkg::REQ_COUNT: begin
                o_cmd.kind = (good && letter_ok) ? lrcas_pkg::K_COUNT : lrcas_pkg::K_ZERO;
            end
            lrcas_pkg::REQ_ASSIGN: begin
                o_cmd.kind = lrcas_pkg::K_ASSIGN;
                drop = !(good && letter_ok);
            end
            lrcas_pkg::REQ_SORT: begin
                o_cmd.kind = lrcas_pkg::K_SORT;
                drop = !good;
            end
            default: begin
                drop = 1'b1;
            end
        endcase
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full && !drop;

endmodule
`default_nettype wire

>>> src/lrcas_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lrcas_queue
// Two-entry command queue between front and back.
// ---------------------------------------------------------------------------
module lrcas_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire lrcas_pkg::t_cmd  i_cmd,
    output logic                  o_full,
    input  wire                   i_pop,
    output logic                  o_valid,
    output lrcas_pkg::t_cmd       o_cmd
);
    lrcas_pkg::t_cmd r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_cmd;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rp];

endmodule
`default_nettype wire

>>> src/lrcas_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lrcas_back
// Executes commands over the letter memory: scans, tallies and run writes.
// ---------------------------------------------------------------------------
module lrcas_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_valid,
    input  wire lrcas_pkg::t_cmd         i_q_cmd,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [lrcas_pkg::POS_W-1:0]  o_count
);
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE
    } t_state;

    localparam logic [lrcas_pkg::LETTER_W-1:0] ALPHA_END =
        lrcas_pkg::LETTER_W'(lrcas_pkg::ALPHABET);

    t_state r_state;
    lrcas_pkg::t_cmd r_cmd;
    logic [lrcas_pkg::POS_W-1:0]    r_pos;
    logic [lrcas_pkg::POS_W-1:0]    r_acc;
    logic [lrcas_pkg::POS_W-1:0]    r_tally [lrcas_pkg::ALPHABET];
    logic [lrcas_pkg::LETTER_W-1:0] r_let;
    logic                           r_rv;
    logic                           r_out_vld;
    logic [lrcas_pkg::POS_W-1:0]    r_out;

    logic [lrcas_pkg::LETTER_W-1:0] mem [lrcas_pkg::MAX_LENGTH];
    logic [lrcas_pkg::LETTER_W-1:0] r_rd;

    logic                           we;
    logic [lrcas_pkg::ADDR_W-1:0]   waddr, addr;
    logic [lrcas_pkg::LETTER_W-1:0] wdata;
    logic [lrcas_pkg::POS_W-1:0]    pos_m1, cur_tally;
    logic                           let_live, skip;

    always_comb begin
        pos_m1    = r_pos - lrcas_pkg::POS_W'(1);
        addr      = pos_m1[lrcas_pkg::ADDR_W-1:0];
        let_live  = (r_let < ALPHA_END);
        cur_tally = let_live ? r_tally[r_let] : '0;
        skip      = (r_cmd.kind == lrcas_pkg::K_SORT) && let_live && (cur_tally == '0);
        we    = 1'b0;
        waddr = addr;
        wdata = lrcas_pkg::EMPTY_CODE;
        if (r_state == S_CLEAR) begin
            we    = 1'b1;
            waddr = r_pos[lrcas_pkg::ADDR_W-1:0];
        end else if (r_state == S_WRITE && !skip) begin
            we = 1'b1;
            if (r_cmd.kind == lrcas_pkg::K_ASSIGN) wdata = r_cmd.letter;
            else if (let_live)                     wdata = r_let;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd <= mem[addr];
    end

    assign o_pop = (r_state == S_IDLE) && i_q_valid && !r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_pos     <= '0;
            r_rv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && i_ready) r_out_vld <= 1'b0;
            r_rv <= (r_state == S_SCAN);
            // tally the word that the previous scan step read, now held in r_rd
            if (r_rv) begin
                if (r_cmd.kind == lrcas_pkg::K_COUNT) begin
                    if (r_rd == r_cmd.letter) r_acc <= r_acc + lrcas_pkg::POS_W'(1);
                end else if (r_rd < ALPHA_END) begin
                    r_tally[r_rd] <= r_tally[r_rd] + lrcas_pkg::POS_W'(1);
                end
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_pos <= r_pos + lrcas_pkg::POS_W'(1);
                    if (r_pos == lrcas_pkg::POS_W'(lrcas_pkg::MAX_LENGTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_q_cmd;
                        r_pos <= i_q_cmd.start;
                        r_acc <= '0;
                        r_let <= '0;
                        for (int i = 0; i < lrcas_pkg::ALPHABET; i++) r_tally[i] <= '0;
                        unique case (i_q_cmd.kind)
                            lrcas_pkg::K_COUNT,
                            lrcas_pkg::K_SORT:   r_state <= S_SCAN;
                            lrcas_pkg::K_ASSIGN: r_state <= S_WRITE;
                            lrcas_pkg::K_ZERO: begin
                                r_out_vld <= 1'b1;
                                r_out     <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_pos == r_cmd.stop) r_state <= S_DRAIN;
                    else                     r_pos   <= r_pos + lrcas_pkg::POS_W'(1);
                end
                S_DRAIN: begin
                    if (r_cmd.kind == lrcas_pkg::K_COUNT) begin
                        r_out_vld <= 1'b1;
                        r_out     <= (r_rd == r_cmd.letter) ?
                                     r_acc + lrcas_pkg::POS_W'(1) : r_acc;
                        r_state   <= S_IDLE;
                    end else begin
                        r_pos   <= r_cmd.start;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (skip) begin
                        r_let <= r_let + lrcas_pkg::LETTER_W'(1);
                    end else begin
                        if (r_cmd.kind == lrcas_pkg::K_SORT && let_live) begin
                            r_tally[r_let] <= cur_tally - lrcas_pkg::POS_W'(1);
                        end
                        if (r_pos == r_cmd.stop) r_state <= S_IDLE;
                        else                     r_pos   <= r_pos + lrcas_pkg::POS_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_vld;
    assign o_count = r_out;

endmodule
`default_nettype wire

>>> sim/tb_letter_range_count_assign_sort_unit.sv
// ---------------------------------------------------------------------------
// tb_letter_range_count_assign_sort_unit
// Self-checking bench for the letter range count/assign/sort unit. A plain
// letter-per-position shadow string predicts every count answer. Directed
// corner cases come first, then random phases at several active lengths and
// idle mixes on both stream sides.
// ---------------------------------------------------------------------------
module tb_letter_range_count_assign_sort_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lrcas_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    // three full-range sorts may sit in flight (executing plus two queued)
    localparam int DRAIN_CYCLES = 6400;
    localparam int STALL_LIMIT  = 40000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [10:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    letter_range_count_assign_sort_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow string, one letter code per position
    logic [lrcas_pkg::LETTER_W-1:0] shadow_str [1:lrcas_pkg::MAX_LENGTH];
    logic [10:0]         shadow_len;
    logic [10:0]         count_q [$];
    int                  errors = 0;
    int                  snd_idle = 22;
    int                  rcv_idle = 74;
    int                  n_sent = 0;
    int                  n_counts = 0;
    int                  stall_cnt = 0;

    function automatic bit range_ok(logic [10:0] x, logic [10:0] y);
        int lim;
        lim = (shadow_len > lrcas_pkg::MAX_LENGTH) ? lrcas_pkg::MAX_LENGTH : shadow_len;
        return (x >= 1) && (x <= y) && (y <= lim);
    endfunction

    function automatic logic [10:0] count_letter(logic [10:0] x, logic [10:0] y,
                                                 logic [4:0] ltr);
        int c;
        c = 0;
        if (range_ok(x, y) && ltr < lrcas_pkg::ALPHABET)
            for (int p = x; p <= y; p++)
                if (shadow_str[p] == ltr) c++;
        return c[10:0];
    endfunction

    task automatic apply_request(logic [1:0] req, logic [10:0] x, logic [10:0] y,
                                 logic [4:0] ltr);
        int tally [lrcas_pkg::ALPHABET];
        int pos;
        if (!range_ok(x, y)) return;
        if (req == lrcas_pkg::REQ_ASSIGN && ltr < lrcas_pkg::ALPHABET) begin
            for (int p = x; p <= y; p++) shadow_str[p] = ltr;
        end else if (req == lrcas_pkg::REQ_SORT) begin
            foreach (tally[a]) tally[a] = 0;
            for (int p = x; p <= y; p++)
                if (shadow_str[p] < lrcas_pkg::ALPHABET) tally[shadow_str[p]]++;
            pos = x;
            for (int a = 0; a < lrcas_pkg::ALPHABET; a++)
                for (int n = 0; n < tally[a]; n++) begin
                    shadow_str[pos] = a[4:0];
                    pos++;
                end
            // empties float to the top of the range
            for (int p = pos; p <= y; p++) shadow_str[p] = lrcas_pkg::EMPTY_CODE;
        end
    endtask

    task automatic send_item(logic [1:0] req, logic [10:0] x, logic [10:0] y,
                             logic [4:0] ltr);
        while ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ltr, y, x, req};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (req == lrcas_pkg::REQ_COUNT) begin
            count_q.push_back(count_letter(x, y, ltr));
            n_counts++;
        end
        apply_request(req, x, y, ltr);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (count_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_length(logic [10:0] len);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        shadow_len   = len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // receiver side: random backpressure and result check
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (count_q.size() == 0) begin
                $error("unexpected letter_count beat: %0d", m_axis_tdata[10:0]);
                errors++;
            end else begin
                if (m_axis_tdata[10:0] !== count_q[0]) begin
                    $error("letter_count: expected %0d, got %0d",
                           count_q[0], m_axis_tdata[10:0]);
                    errors++;
                end
                void'(count_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("FAIL letter_range_count_assign_sort_unit");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(lrcas_pkg::REQ_COUNT, 11'd1, 11'd1024, 5'd0);      // empty string
        send_item(lrcas_pkg::REQ_ASSIGN, 11'd1, 11'd1024, 5'd25);
        send_item(lrcas_pkg::REQ_COUNT, 11'd1, 11'd1024, 5'd25);     // full 1024
        send_item(lrcas_pkg::REQ_ASSIGN, 11'd1, 11'd1, 5'd0);
        send_item(lrcas_pkg::REQ_ASSIGN, 11'd1024, 11'd1024, 5'd3);
        send_item(lrcas_pkg::REQ_ASSIGN, 11'd10, 11'd19, 5'd31);     // letter outside alphabet
        send_item(lrcas_pkg::REQ_COUNT, 11'd10, 11'd19, 5'd31);
        send_item(lrcas_pkg::REQ_COUNT, 11'd0, 11'd5, 5'd25);        // x of zero
        send_item(lrcas_pkg::REQ_COUNT, 11'd9, 11'd8, 5'd25);        // x above y
        send_item(lrcas_pkg::REQ_COUNT, 11'd1000, 11'd1025, 5'd25);  // y past length
        send_item(lrcas_pkg::REQ_COUNT, 11'd2047, 11'd2047, 5'd25);
        send_item(lrcas_pkg::REQ_ASSIGN, 11'd9, 11'd8, 5'd1);
        send_item(lrcas_pkg::REQ_SORT, 11'd0, 11'd2047, 5'd0);
        send_item(REQ_UNUSED, 11'd1, 11'd1024, 5'd1);
        send_item(lrcas_pkg::REQ_ASSIGN, 11'd1, 11'd1024, 5'd7);
        send_item(lrcas_pkg::REQ_SORT, 11'd1, 11'd1024, 5'd0);       // full-range sort
        send_item(lrcas_pkg::REQ_COUNT, 11'd1, 11'd1024, 5'd3);
        send_item(lrcas_pkg::REQ_COUNT, 11'd1, 11'd1, 5'd0);
        send_item(lrcas_pkg::REQ_COUNT, 11'd1024, 11'd1024, 5'd25);
        send_item(lrcas_pkg::REQ_COUNT, 11'd500, 11'd600, 5'd7);
    endtask

    task automatic test_empty_sort();
        // an out-of-alphabet assign is dropped; sorts then regroup the short runs
        send_item(lrcas_pkg::REQ_ASSIGN, 11'd1, 11'd40, 5'd31);
        send_item(lrcas_pkg::REQ_SORT, 11'd1, 11'd40, 5'd0);
        send_item(lrcas_pkg::REQ_ASSIGN, 11'd3, 11'd4, 5'd12);
        send_item(lrcas_pkg::REQ_ASSIGN, 11'd20, 11'd21, 5'd2);
        send_item(lrcas_pkg::REQ_SORT, 11'd1, 11'd30, 5'd0);
        for (int l = 0; l < 32; l += 5)
            send_item(lrcas_pkg::REQ_COUNT, 11'd1, 11'd30, l[4:0]);
    endtask

    task automatic test_short_lengths();
        set_length(11'd1);
        send_item(lrcas_pkg::REQ_ASSIGN, 11'd1, 11'd1, 5'd9);
        send_item(lrcas_pkg::REQ_COUNT, 11'd1, 11'd1, 5'd9);
        send_item(lrcas_pkg::REQ_COUNT, 11'd1, 11'd2, 5'd9);
        set_length(11'd0);
        send_item(lrcas_pkg::REQ_COUNT, 11'd1, 11'd1, 5'd9);
        send_item(lrcas_pkg::REQ_ASSIGN, 11'd1, 11'd1, 5'd4);
        set_length(11'd2047);
        send_item(lrcas_pkg::REQ_COUNT, 11'd1, 11'd1, 5'd9);
        send_item(lrcas_pkg::REQ_COUNT, 11'd1, 11'd1025, 5'd9);
    endtask

    task automatic test_random(int n);
        int lim, x, y, kind;
        logic [1:0] req;
        logic [4:0] ltr;
        for (int i = 0; i < n; i++) begin
            lim = (shadow_len > lrcas_pkg::MAX_LENGTH) ? lrcas_pkg::MAX_LENGTH : shadow_len;
            if (lim < 1) lim = 1;
            kind = $urandom_range(99);
            if (kind < 6) begin
                req = 2'($urandom_range(3));
                x   = $urandom_range(2047);
                y   = $urandom_range(2047);
                ltr = 5'($urandom_range(31));
            end else begin
                req = (kind < 45) ? lrcas_pkg::REQ_COUNT :
                      (kind < 82) ? lrcas_pkg::REQ_ASSIGN : lrcas_pkg::REQ_SORT;
                if ($urandom_range(59) == 0) begin
                    x = 1;
                    y = lim;
                end else begin
                    x = $urandom_range(lim, 1);
                    y = x + $urandom_range(15);
                    if (y > lim) y = lim;
                end
                ltr = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) :
                                                  5'($urandom_range(25));
            end
            send_item(req, x[10:0], y[10:0], ltr);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        for (int p = 1; p <= lrcas_pkg::MAX_LENGTH; p++) shadow_str[p] = lrcas_pkg::EMPTY_CODE;
        shadow_len = 11'd1024;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_empty_sort();
        test_short_lengths();

        set_length(11'd1024);
        snd_idle = 22;
        rcv_idle = 74;
        test_random(700);

        set_length(11'd200);
        snd_idle = 74;
        rcv_idle = 22;
        test_random(600);

        set_length(11'd2047);
        snd_idle = 0;
        rcv_idle = 0;
        test_random(300);
        wait_drained();
        test_random(300);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests (%0d counts checked) over active lengths 0..2047,",
                 n_sent, n_counts);
        $display("with directed corners, empty-cell sorts and mixed stream backpressure.");
        if (errors == 0)
            $display("PASS letter_range_count_assign_sort_unit");
        else
            $display("FAIL letter_range_count_assign_sort_unit");
        $finish;
    end
endmodule
